FILE: design/rgb_white_balance_color_classifier_core_macros.svh
// ----------------------------------------------------------------------------
// RGB white balance / color classifier - assertion macros
// Shared concurrent assertion forms used by the core top level.
// ----------------------------------------------------------------------------
`ifndef RGB_WHITE_BALANCE_COLOR_CLASSIFIER_CORE_MACROS_SVH
`define RGB_WHITE_BALANCE_COLOR_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, suspended while reset is low.
`define RGBWB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Implication that lands a fixed number of cycles later.
`define RGBWB_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> ##dly (cons)) else $error(msg);

`endif

FILE: design/rgbwb_pkg.sv
// ----------------------------------------------------------------------------
// RGB white balance / color classifier - package
// Payload types, register map, reset values and color codes.
// ----------------------------------------------------------------------------
package rgbwb_pkg;

    localparam int CH_W            = 16;   // channel / reference width
    localparam int PCT_W           = 7;    // margin register width
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int NUM_LANES       = 3;
    localparam int ADDR_W          = 5;    // six 32-bit registers
    localparam int DATA_W          = 32;
    localparam int IDX_W           = 3;

    // Raw register, multiplier, overflow check, one stage per quotient bit,
    // saturation.
    localparam int LANE_LAT = CH_W + 4;
    localparam int CLS_LAT  = 3;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    localparam logic [IDX_W-1:0] REG_RED_REF   = 3'd0;
    localparam logic [IDX_W-1:0] REG_GREEN_REF = 3'd1;
    localparam logic [IDX_W-1:0] REG_BLUE_REF  = 3'd2;
    localparam logic [IDX_W-1:0] REG_FULL_SCL  = 3'd3;
    localparam logic [IDX_W-1:0] REG_PRIM_PCT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_FLAT_PCT  = 3'd5;

    localparam logic [CH_W-1:0]  RST_RED_REF   = 16'd8685;
    localparam logic [CH_W-1:0]  RST_GREEN_REF = 16'd8716;
    localparam logic [CH_W-1:0]  RST_BLUE_REF  = 16'd5886;
    localparam logic [CH_W-1:0]  RST_FULL_SCL  = 16'd17999;
    localparam logic [PCT_W-1:0] RST_PRIM_PCT  = 7'd20;
    localparam logic [PCT_W-1:0] RST_FLAT_PCT  = 7'd5;

    typedef enum logic [2:0] {
        COL_NONE    = 3'd0,
        COL_RED     = 3'd1,
        COL_GREEN   = 3'd2,
        COL_BLUE    = 3'd3,
        COL_YELLOW  = 3'd4,
        COL_CYAN    = 3'd5,
        COL_MAGENTA = 3'd6
    } t_color;

    typedef struct packed {
        logic [CH_W-1:0] red_raw;
        logic [CH_W-1:0] green_raw;
        logic [CH_W-1:0] blue_raw;
    } t_rgbwb_in;

    typedef struct packed {
        logic [CH_W-1:0] red_balanced;
        logic [CH_W-1:0] green_balanced;
        logic [CH_W-1:0] blue_balanced;
        logic [2:0]      detected_color;
        logic [2:0]      opposing_color;
    } t_rgbwb_out;

    function automatic t_color opposing(input t_color c);
        t_color o;
        unique case (c)
            COL_RED:     o = COL_YELLOW;
            COL_GREEN:   o = COL_MAGENTA;
            COL_BLUE:    o = COL_CYAN;
            COL_YELLOW:  o = COL_RED;
            COL_CYAN:    o = COL_BLUE;
            COL_MAGENTA: o = COL_GREEN;
            default:     o = COL_NONE;
        endcase
        return o;
    endfunction

endpackage

FILE: design/rgb_white_balance_color_classifier_core.sv
// ----------------------------------------------------------------------------
// RGB white balance and color classifier core
// Takes one raw RGB sample per cycle and returns the balanced channels with
// the detected and opposing color after the lane and classification stages.
// ----------------------------------------------------------------------------
// A sample is taken on every clock edge with start high; busy never rises, so
// one sample per cycle is sustained. Each result appears on o_out for one
// cycle with o_valid high, in order, and cannot be held off: capture it when
// it shows. The pipeline is the input register, the multiply, the overflow
// check, the per-channel divider with one quotient bit per pipeline stage (16
// stages), the saturation stage and three classification stages. The user
// must write registers over the APB port only while no sample is in flight;
// the block itself does not enforce this.
module rgb_white_balance_color_classifier_core #(
    parameter int SAMPLE_BITS = rgbwb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rgbwb_pkg::t_rgbwb_in          i_in,
    output logic                          o_valid,
    output rgbwb_pkg::t_rgbwb_out         o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rgbwb_pkg::ADDR_W-1:0]  paddr,
    input  logic [rgbwb_pkg::DATA_W-1:0]  pwdata,
    output logic [rgbwb_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);
    import rgbwb_pkg::*;

    `include "rgb_white_balance_color_classifier_core_macros.svh"

    localparam int TOTAL_LAT = LANE_LAT + CLS_LAT;

    logic [CH_W-1:0]  r_red_ref;
    logic [CH_W-1:0]  r_green_ref;
    logic [CH_W-1:0]  r_blue_ref;
    logic [CH_W-1:0]  r_full_scale;
    logic [PCT_W-1:0] r_prim_pct;
    logic [PCT_W-1:0] r_flat_pct;
    logic [CH_W-1:0]  r_maxref;
    logic [CH_W-1:0]  n_maxref;

    logic             w_wr;
    logic [IDX_W-1:0] w_idx;
    logic             w_accept;

    logic [CH_W-1:0]      w_raw      [0:NUM_LANES-1];
    logic [CH_W-1:0]      w_ref      [0:NUM_LANES-1];
    logic [CH_W-1:0]      w_bal      [0:NUM_LANES-1];
    logic [NUM_LANES-1:0] w_lane_vld;

    assign busy     = 1'b0;
    assign pready   = 1'b1;
    assign w_accept = start && !busy;
    assign w_wr     = psel && penable && pwrite && pready;
    assign w_idx    = paddr[ADDR_W-1:2];

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_ref    <= RST_RED_REF;
            r_green_ref  <= RST_GREEN_REF;
            r_blue_ref   <= RST_BLUE_REF;
            r_full_scale <= RST_FULL_SCL;
            r_prim_pct   <= RST_PRIM_PCT;
            r_flat_pct   <= RST_FLAT_PCT;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RED_REF:   r_red_ref    <= pwdata[CH_W-1:0];
                REG_GREEN_REF: r_green_ref  <= pwdata[CH_W-1:0];
                REG_BLUE_REF:  r_blue_ref   <= pwdata[CH_W-1:0];
                REG_FULL_SCL:  r_full_scale <= pwdata[CH_W-1:0];
                REG_PRIM_PCT:  r_prim_pct   <= pwdata[PCT_W-1:0];
                REG_FLAT_PCT:  r_flat_pct   <= pwdata[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_RED_REF:   prdata = DATA_W'(r_red_ref);
            REG_GREEN_REF: prdata = DATA_W'(r_green_ref);
            REG_BLUE_REF:  prdata = DATA_W'(r_blue_ref);
            REG_FULL_SCL:  prdata = DATA_W'(r_full_scale);
            REG_PRIM_PCT:  prdata = DATA_W'(r_prim_pct);
            REG_FLAT_PCT:  prdata = DATA_W'(r_flat_pct);
            default:       prdata = '0;
        endcase
    end

    // Largest reference, shared by all lanes; registered, so it settles in the
    // cycle after a write, before any sample reaches the multiplier.
    always_comb begin
        n_maxref = r_red_ref;
        if (r_green_ref > n_maxref) n_maxref = r_green_ref;
        if (r_blue_ref > n_maxref)  n_maxref = r_blue_ref;
    end

    always_ff @(posedge i_clk) begin
        r_maxref <= n_maxref;
    end

    assign w_raw[0] = i_in.red_raw;
    assign w_raw[1] = i_in.green_raw;
    assign w_raw[2] = i_in.blue_raw;
    assign w_ref[0] = r_red_ref;
    assign w_ref[1] = r_green_ref;
    assign w_ref[2] = r_blue_ref;

    genvar ln;
    generate
        for (ln = 0; ln < NUM_LANES; ln++) begin : g_lane
            rgbwb_lane #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_valid      (w_accept),
                .i_raw        (w_raw[ln]),
                .i_ref        (w_ref[ln]),
                .i_maxref     (r_maxref),
                .i_full_scale (r_full_scale),
                .o_valid      (w_lane_vld[ln]),
                .o_balanced   (w_bal[ln])
            );
        end
    endgenerate

    rgbwb_classify u_classify (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (&w_lane_vld),
        .i_ch       (w_bal),
        .i_prim_pct (r_prim_pct),
        .i_flat_pct (r_flat_pct),
        .o_valid    (o_valid),
        .o_out      (o_out)
    );

    // Lanes advance in lockstep.
    `RGBWB_ASSERT_IMPLY(a_lane_lockstep, i_clk, i_rst_n, 1'b1, (w_lane_vld == '0) || (w_lane_vld == '1), "lanes out of step")
    // Every accepted sample produces exactly one beat after the fixed latency.
    `RGBWB_ASSERT_DELAY(a_fixed_latency, i_clk, i_rst_n, w_accept, TOTAL_LAT, o_valid, "result beat missing")
    // No color maps to no color, and a real color never opposes to none.
    `RGBWB_ASSERT_IMPLY(a_none_pairs, i_clk, i_rst_n, o_valid, (o_out.detected_color == COL_NONE) == (o_out.opposing_color == COL_NONE), "opposing color mismatch")

endmodule

FILE: design/rgbwb_lane.sv
// ----------------------------------------------------------------------------
// RGB white balance lane
// Scales one raw channel by maxref/ref through a pipelined restoring divider
// and saturates the quotient at full scale.
// ----------------------------------------------------------------------------
module rgbwb_lane #(
    parameter int SAMPLE_BITS = rgbwb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [rgbwb_pkg::CH_W-1:0] i_raw,
    input  logic [rgbwb_pkg::CH_W-1:0] i_ref,
    input  logic [rgbwb_pkg::CH_W-1:0] i_maxref,
    input  logic [rgbwb_pkg::CH_W-1:0] i_full_scale,
    output logic                      o_valid,
    output logic [rgbwb_pkg::CH_W-1:0] o_balanced
);
    import rgbwb_pkg::*;

    localparam int RAW_W = (SAMPLE_BITS < CH_W) ? SAMPLE_BITS : CH_W;
    localparam int NUM_W = RAW_W + CH_W;

    logic             r_v_raw;
    logic [RAW_W-1:0] r_raw;
    logic             r_v_num;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] n_num;

    logic [CH_W-1:0]  w_hi;

    logic             r_dv  [0:CH_W];
    logic             r_sat [0:CH_W];
    logic [CH_W-1:0]  r_rem [0:CH_W];
    logic [CH_W-1:0]  r_low [0:CH_W];
    logic [CH_W-1:0]  r_q   [0:CH_W];

    logic             r_v_out;
    logic [CH_W-1:0]  r_bal;
    logic [CH_W-1:0]  n_bal;

    assign n_num = NUM_W'(r_raw) * NUM_W'(i_maxref);
    assign w_hi  = CH_W'(r_num[NUM_W-1:CH_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_raw  <= 1'b0;
            r_v_num  <= 1'b0;
            r_dv[0]  <= 1'b0;
        end else begin
            r_v_raw  <= i_valid;
            r_v_num  <= r_v_raw;
            r_dv[0]  <= r_v_num;
        end
        r_raw    <= i_raw[RAW_W-1:0];
        r_num    <= n_num;
        // A high part at or above the reference means a quotient of 2^16 or
        // more; a zero reference always lands here too.
        r_sat[0] <= (w_hi >= i_ref);
        r_rem[0] <= w_hi;
        r_low[0] <= r_num[CH_W-1:0];
        r_q[0]   <= '0;
    end

    genvar k;
    generate
        for (k = 0; k < CH_W; k++) begin : g_div
            logic [CH_W:0] w_trial;
            logic [CH_W:0] w_diff;
            logic          w_ge;

            assign w_trial = {r_rem[k], r_low[k][CH_W-1]};
            assign w_diff  = w_trial - {1'b0, i_ref};
            assign w_ge    = (w_trial >= {1'b0, i_ref});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[k+1] <= 1'b0;
                end else begin
                    r_dv[k+1] <= r_dv[k];
                end
                r_sat[k+1] <= r_sat[k];
                r_rem[k+1] <= w_ge ? w_diff[CH_W-1:0] : w_trial[CH_W-1:0];
                r_low[k+1] <= {r_low[k][CH_W-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][CH_W-2:0], w_ge};
            end
        end
    endgenerate

    assign n_bal = (r_sat[CH_W] || (r_q[CH_W] > i_full_scale)) ? i_full_scale
                                                                 : r_q[CH_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_out <= 1'b0;
        end else begin
            r_v_out <= r_dv[CH_W];
        end
        r_bal <= n_bal;
    end

    assign o_valid    = r_v_out;
    assign o_balanced = r_bal;

endmodule

FILE: design/rgbwb_classify.sv
// ----------------------------------------------------------------------------
// RGB color classifier merge stage
// Combines the three balanced lanes into a detected and an opposing color.
// ----------------------------------------------------------------------------
module rgbwb_classify (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [rgbwb_pkg::CH_W-1:0]  i_ch [0:rgbwb_pkg::NUM_LANES-1],
    input  logic [rgbwb_pkg::PCT_W-1:0] i_prim_pct,
    input  logic [rgbwb_pkg::PCT_W-1:0] i_flat_pct,
    output logic                        o_valid,
    output rgbwb_pkg::t_rgbwb_out       o_out
);
    import rgbwb_pkg::*;

    localparam int PROD_W = CH_W + PCT_W + 1;

    // stage 1: extremes
    logic             r_v1;
    logic [CH_W-1:0]  r_c1 [0:NUM_LANES-1];
    logic [CH_W-1:0]  r_mx;
    logic [CH_W-1:0]  r_mn;
    logic [CH_W-1:0]  n_mx;
    logic [CH_W-1:0]  n_mn;

    // stage 2: scaled products
    logic              r_v2;
    logic [CH_W-1:0]   r_c2    [0:NUM_LANES-1];
    logic [PROD_W-1:0] r_c100  [0:NUM_LANES-1];
    logic [PROD_W-1:0] r_cmarg [0:NUM_LANES-1];
    logic [PROD_W-1:0] r_spread;
    logic [PROD_W-1:0] r_flat;
    logic [PCT_W:0]    w_marg;

    // stage 3: decision
    logic              w_beat [0:NUM_LANES-1][0:NUM_LANES-1];
    t_color            n_col;
    logic              r_v3;
    t_rgbwb_out        r_out;

    always_comb begin
        n_mx = i_ch[0];
        n_mn = i_ch[0];
        for (int i = 1; i < NUM_LANES; i++) begin
            if (i_ch[i] > n_mx) n_mx = i_ch[i];
            if (i_ch[i] < n_mn) n_mn = i_ch[i];
        end
    end

    assign w_marg = (PCT_W+1)'(PCT_FULL) + (PCT_W+1)'(i_prim_pct);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_c1     <= i_ch;
        r_mx     <= n_mx;
        r_mn     <= n_mn;
        r_c2     <= r_c1;
        r_spread <= PROD_W'(r_mx - r_mn) * PROD_W'(PCT_FULL);
        r_flat   <= PROD_W'(r_mx) * PROD_W'(i_flat_pct);
        for (int i = 0; i < NUM_LANES; i++) begin
            r_c100[i]  <= PROD_W'(r_c1[i]) * PROD_W'(PCT_FULL);
            r_cmarg[i] <= PROD_W'(r_c1[i]) * PROD_W'(w_marg);
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            for (int j = 0; j < NUM_LANES; j++) begin
                w_beat[i][j] = (r_c100[i] > r_cmarg[j]);
            end
        end
    end

    always_comb begin
        priority if (r_spread <= r_flat) begin
            n_col = COL_NONE;
        end else if (w_beat[0][1] && w_beat[0][2]) begin
            n_col = COL_RED;
        end else if (w_beat[1][0] && w_beat[1][2]) begin
            n_col = COL_GREEN;
        end else if (w_beat[2][0] && w_beat[2][1]) begin
            n_col = COL_BLUE;
        end else if ((r_c2[0] > r_c2[2]) && (r_c2[1] > r_c2[2])) begin
            n_col = COL_YELLOW;
        end else if ((r_c2[1] > r_c2[0]) && (r_c2[2] > r_c2[0])) begin
            n_col = COL_CYAN;
        end else if ((r_c2[0] > r_c2[1]) && (r_c2[2] > r_c2[1])) begin
            n_col = COL_MAGENTA;
        end else begin
            n_col = COL_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_out.red_balanced   <= r_c2[0];
        r_out.green_balanced <= r_c2[1];
        r_out.blue_balanced  <= r_c2[2];
        r_out.detected_color <= n_col;
        r_out.opposing_color <= opposing(n_col);
    end

    assign o_valid = r_v3;
    assign o_out   = r_out;

endmodule

FILE: dv/rgbwb_color_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB white balance / color classifier - result checker
// Tracks the register file from APB writes, predicts the balanced channels
// and color pair for every accepted sample, and compares each result beat
// against the oldest prediction. APB reads of known registers are checked too.
// ----------------------------------------------------------------------------
module rgbwb_color_checker
    import rgbwb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_rgbwb_in         i_in,
    input  logic              i_valid,
    input  t_rgbwb_out        i_out,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    input  logic [DATA_W-1:0] i_prdata,
    input  logic              i_pready,
    output int                o_fail_count,
    output int                o_pixels_in_flight
);

    logic [CH_W-1:0]  red_ref;
    logic [CH_W-1:0]  green_ref;
    logic [CH_W-1:0]  blue_ref;
    logic [CH_W-1:0]  full_scl;
    logic [PCT_W-1:0] prim_pct;
    logic [PCT_W-1:0] flat_pct;

    t_rgbwb_out expected_pixels[$];
    int         mismatches = 0;
    int         in_flight  = 0;

    assign o_fail_count       = mismatches;
    assign o_pixels_in_flight = in_flight;

    function automatic logic [CH_W-1:0] balance_channel(
        input logic [CH_W-1:0] raw,
        input logic [CH_W-1:0] chan_ref,
        input logic [CH_W-1:0] max_ref
    );
        logic [63:0] quot;
        // a channel with no reference reads as full scale
        if (chan_ref == '0) begin
            return full_scl;
        end
        quot = (64'(raw) * 64'(max_ref)) / 64'(chan_ref);
        return (quot > 64'(full_scl)) ? full_scl : quot[CH_W-1:0];
    endfunction

    function automatic bit dominates(input logic [CH_W-1:0] c, input logic [CH_W-1:0] o);
        return (64'd100 * 64'(c)) > (64'(o) * (64'd100 + 64'(prim_pct)));
    endfunction

    function automatic t_color classify_color(
        input logic [CH_W-1:0] r,
        input logic [CH_W-1:0] g,
        input logic [CH_W-1:0] b
    );
        logic [CH_W-1:0] mx;
        logic [CH_W-1:0] mn;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        if (64'd100 * 64'(mx - mn) <= 64'(mx) * 64'(flat_pct)) return COL_NONE;
        if (dominates(r, g) && dominates(r, b)) return COL_RED;
        if (dominates(g, r) && dominates(g, b)) return COL_GREEN;
        if (dominates(b, r) && dominates(b, g)) return COL_BLUE;
        if (r > b && g > b) return COL_YELLOW;
        if (g > r && b > r) return COL_CYAN;
        if (r > g && b > g) return COL_MAGENTA;
        return COL_NONE;
    endfunction

    function automatic t_color complement_color(input t_color c);
        case (c)
            COL_RED:     return COL_YELLOW;
            COL_YELLOW:  return COL_RED;
            COL_GREEN:   return COL_MAGENTA;
            COL_MAGENTA: return COL_GREEN;
            COL_BLUE:    return COL_CYAN;
            COL_CYAN:    return COL_BLUE;
            default:     return COL_NONE;
        endcase
    endfunction

    function automatic t_rgbwb_out balance_and_classify(input t_rgbwb_in px);
        t_rgbwb_out      res;
        logic [CH_W-1:0] max_ref;
        t_color          col;
        max_ref = red_ref;
        if (green_ref > max_ref) max_ref = green_ref;
        if (blue_ref > max_ref) max_ref = blue_ref;
        res.red_balanced   = balance_channel(px.red_raw, red_ref, max_ref);
        res.green_balanced = balance_channel(px.green_raw, green_ref, max_ref);
        res.blue_balanced  = balance_channel(px.blue_raw, blue_ref, max_ref);
        col = classify_color(res.red_balanced, res.green_balanced, res.blue_balanced);
        res.detected_color = col;
        res.opposing_color = complement_color(col);
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] reg_value(input logic [IDX_W-1:0] idx);
        case (idx)
            REG_RED_REF:   return DATA_W'(red_ref);
            REG_GREEN_REF: return DATA_W'(green_ref);
            REG_BLUE_REF:  return DATA_W'(blue_ref);
            REG_FULL_SCL:  return DATA_W'(full_scl);
            REG_PRIM_PCT:  return DATA_W'(prim_pct);
            default:       return DATA_W'(flat_pct);
        endcase
    endfunction

    task automatic note_failure(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    always @(posedge i_clk) begin
        t_rgbwb_out       want;
        logic [IDX_W-1:0] idx;
        idx = i_paddr[ADDR_W-1:2];
        if (!i_rst_n) begin
            red_ref   = RST_RED_REF;
            green_ref = RST_GREEN_REF;
            blue_ref  = RST_BLUE_REF;
            full_scl  = RST_FULL_SCL;
            prim_pct  = RST_PRIM_PCT;
            flat_pct  = RST_FLAT_PCT;
            expected_pixels.delete();
        end else begin
            if (i_valid) begin
                if (expected_pixels.size() == 0) begin
                    note_failure($sformatf("result beat with nothing outstanding: %h", i_out));
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_out.red_balanced !== want.red_balanced ||
                        i_out.green_balanced !== want.green_balanced ||
                        i_out.blue_balanced !== want.blue_balanced ||
                        i_out.detected_color !== want.detected_color ||
                        i_out.opposing_color !== want.opposing_color) begin
                        note_failure($sformatf(
                            "mismatch: exp r=%0d g=%0d b=%0d col=%0d opp=%0d, got r=%0d g=%0d b=%0d col=%0d opp=%0d",
                            want.red_balanced, want.green_balanced, want.blue_balanced,
                            want.detected_color, want.opposing_color,
                            i_out.red_balanced, i_out.green_balanced, i_out.blue_balanced,
                            i_out.detected_color, i_out.opposing_color));
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_pixels.push_back(balance_and_classify(i_in));
            end
            if (i_psel && i_penable && i_pready) begin
                if (!i_pwrite) begin
                    // addresses past the last register read as zero and are not checked
                    if (idx <= REG_FLAT_PCT && i_prdata !== reg_value(idx)) begin
                        note_failure($sformatf("register %0d reads %h, expected %h",
                                               idx, i_prdata, reg_value(idx)));
                    end
                end else begin
                    case (idx)
                        REG_RED_REF:   red_ref   = i_pwdata[CH_W-1:0];
                        REG_GREEN_REF: green_ref = i_pwdata[CH_W-1:0];
                        REG_BLUE_REF:  blue_ref  = i_pwdata[CH_W-1:0];
                        REG_FULL_SCL:  full_scl  = i_pwdata[CH_W-1:0];
                        REG_PRIM_PCT:  prim_pct  = i_pwdata[PCT_W-1:0];
                        REG_FLAT_PCT:  flat_pct  = i_pwdata[PCT_W-1:0];
                        default: ;
                    endcase
                end
            end
        end
        in_flight = expected_pixels.size();
    end

endmodule

FILE: dv/tb_rgb_white_balance_color_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB white balance / color classifier - testbench top
// Drives samples and APB register writes into the core: a directed pass over
// every color, the margin boundaries, saturation and zero references, then
// random samples under a series of register settings with random gaps.
// ----------------------------------------------------------------------------
module tb_rgb_white_balance_color_classifier_core;
    import rgbwb_pkg::*;

    // addresses past the register file, written to confirm they are ignored
    localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    t_rgbwb_in         i_in    = '0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic              busy;
    logic              o_valid;
    t_rgbwb_out        o_out;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                pixels_in_flight;

    rgb_white_balance_color_classifier_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_valid (o_valid),
        .o_out   (o_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rgbwb_color_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_in               (i_in),
        .i_valid            (o_valid),
        .i_out              (o_out),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .i_prdata           (prdata),
        .i_pready           (pready),
        .o_fail_count       (fail_count),
        .o_pixels_in_flight (pixels_in_flight)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_rgbwb_in rgb(input int unsigned r, input int unsigned g,
                                      input int unsigned b);
        return {r[CH_W-1:0], g[CH_W-1:0], b[CH_W-1:0]};
    endfunction

    // Mix of plain noise, near-gray, one dominant, two dominant and rail values.
    function automatic t_rgbwb_in make_pixel();
        logic [CH_W-1:0] ch[3];
        int unsigned     hi;
        int unsigned     pick;
        int unsigned     kind;
        kind = $urandom_range(0, 9);
        hi   = $urandom_range(4096, 65535);
        pick = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
            case (kind)
                0, 1, 2: ch[k] = CH_W'($urandom);
                3, 4:    ch[k] = CH_W'(hi - $urandom_range(0, hi / 12));
                5, 6:    ch[k] = (k == pick) ? CH_W'(hi)
                                             : CH_W'($urandom_range(0, hi * 9 / 10));
                7, 8:    ch[k] = (k == pick) ? CH_W'($urandom_range(0, hi / 2))
                                             : CH_W'(hi - $urandom_range(0, hi / 10));
                default: ch[k] = ($urandom_range(0, 1) != 0) ? 16'hFFFF
                                                             : CH_W'($urandom_range(0, 3));
            endcase
        end
        return {ch[0], ch[1], ch[2]};
    endfunction

    task automatic reg_access(input bit wr, input logic [IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_pixel(input t_rgbwb_in px);
        @(negedge i_clk);
        start <= 1'b1;
        i_in  <= px;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_gap(input bit bursty);
        int unsigned n;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (bursty || roll < 45) n = 0;
        else if (roll < 85) n = $urandom_range(1, 3);
        else if (roll < 96) n = $urandom_range(4, 12);
        else n = $urandom_range(20, 60);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_in  <= make_pixel();
        end
    endtask

    // Hold off new samples until every result beat is back.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (pixels_in_flight != 0) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [DATA_W-1:0] rr, input logic [DATA_W-1:0] gr,
                              input logic [DATA_W-1:0] br, input logic [DATA_W-1:0] fs,
                              input logic [DATA_W-1:0] pp, input logic [DATA_W-1:0] fp);
        drain();
        reg_access(1'b1, REG_RED_REF, rr);
        reg_access(1'b1, REG_GREEN_REF, gr);
        reg_access(1'b1, REG_BLUE_REF, br);
        reg_access(1'b1, REG_FULL_SCL, fs);
        reg_access(1'b1, REG_PRIM_PCT, pp);
        reg_access(1'b1, REG_FLAT_PCT, fp);
        reg_access(1'b1, IDX_SPARE_LO, $urandom);
        reg_access(1'b1, IDX_SPARE_HI, $urandom);
        for (int k = REG_RED_REF; k <= REG_FLAT_PCT; k++) begin
            reg_access(1'b0, IDX_W'(k), '0);
        end
    endtask

    task automatic directed(input int unsigned r, input int unsigned g, input int unsigned b);
        send_pixel(rgb(r, g, b));
        idle_gap(1'b0);
    endtask

    task automatic run_pixels(input int n, input bit bursty, input int pause_at);
        for (int i = 0; i < n; i++) begin
            send_pixel(make_pixel());
            if (i == pause_at) drain();
            else idle_gap(bursty);
        end
    endtask

    initial begin
        logic [DATA_W-1:0] refs[3];
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values, then near-white at the reset references
        for (int k = REG_RED_REF; k <= REG_FLAT_PCT; k++) begin
            reg_access(1'b0, IDX_W'(k), '0);
        end
        directed(0, 0, 0);
        directed(16'hFFFF, 16'hFFFF, 16'hFFFF);
        directed(8685, 8716, 5886);

        // unit gain: balanced equals raw
        set_config(1000, 1000, 1000, 65535, 20, 5);
        directed(60000, 1000, 1000);
        directed(1000, 60000, 1000);
        directed(1000, 1000, 60000);
        directed(50000, 50000, 1000);
        directed(1000, 50000, 50000);
        directed(50000, 1000, 50000);
        directed(120, 100, 100);     // primary tie, falls through to none
        directed(121, 100, 100);     // just past the primary margin
        directed(100, 95, 97);       // spread exactly at the flat margin
        directed(100, 94, 97);
        directed(50000, 50000, 50000);
        directed(0, 0, 1);
        directed(16'hFFFF, 0, 0);

        // saturation at full scale
        set_config(1000, 1000, 1, 40000, 20, 5);
        directed(10, 10, 100);
        directed(16'hFFFF, 16'hFFFF, 16'hFFFF);

        // zero reference reads as full scale
        set_config(0, 1000, 1000, 30000, 0, 0);
        directed(0, 0, 0);
        directed(12345, 500, 400);

        // margins above one hundred
        set_config(1000, 1000, 1000, 65535, 127, 127);
        directed(60000, 10, 10);
        directed(10, 10, 60000);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_config(RST_RED_REF, RST_GREEN_REF, RST_BLUE_REF, RST_FULL_SCL,
                              RST_PRIM_PCT, RST_FLAT_PCT);
                1: set_config($urandom_range(1, 65535), $urandom_range(1, 65535),
                              $urandom_range(1, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 100), $urandom_range(0, 20));
                2: set_config(65535, 65535, 65535, 65535, 0, 0);
                3: set_config(32'hFFFF_0000 | $urandom_range(1, 65535),
                              32'hFFFF_0000 | $urandom_range(1, 65535),
                              32'hFFFF_0000 | $urandom_range(1, 65535),
                              32'hFFFF_0000 | $urandom_range(0, 65535),
                              32'hFFFF_FF80 | $urandom_range(0, 100),
                              32'hFFFF_FF80 | $urandom_range(0, 100));
                4: begin
                    for (int k = 0; k < 3; k++) refs[k] = $urandom_range(1, 65535);
                    refs[$urandom_range(0, 2)] = '0;
                    set_config(refs[0], refs[1], refs[2], $urandom_range(1, 65535),
                               $urandom_range(0, 40), $urandom_range(0, 10));
                end
                5: set_config(1, 65535, $urandom_range(1, 65535), 65535,
                              $urandom_range(0, 100), 100);
                6: set_config($urandom_range(1, 65535), $urandom_range(1, 65535),
                              $urandom_range(1, 65535), 0, 20, 5);
                default: set_config($urandom_range(1, 65535), $urandom_range(1, 65535),
                                    $urandom_range(1, 65535), $urandom_range(20000, 65535),
                                    $urandom_range(5, 30), $urandom_range(0, 8));
            endcase
            run_pixels(60, (p == 2) || (p == 7), (p == 1) ? 30 : -1);
        end

        drain();
        repeat (LANE_LAT + CLS_LAT + 8) @(negedge i_clk);
        if (fail_count == 0 && pixels_in_flight == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
